>>> rtl/iir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_pkg: shared types, constants and arithmetic helpers
// Widths of the biquad datapath, register indexes, the request and result
// payloads, and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package iir_pkg;

  // Field and arithmetic widths.
  localparam int FILTER_ORDER   = 2;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 18;
  localparam int COEF_FRAC_BITS = 16;
  localparam int DELAY_BITS     = 40;
  localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS       = DELAY_BITS + 2;
  localparam int DIFF_BITS      = DELAY_BITS + 3;
  localparam int CFG_INDEX_BITS = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_B0     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_B1     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_B2     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_A1     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_A2     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BYPASS = 3'd5;

  // Reset value of b0 is unity gain.
  localparam logic signed [COEF_BITS-1:0] COEF_ONE =
    {{(COEF_BITS-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};

  // Rounding offset and saturation limits at accumulator width.
  localparam logic signed [ACC_BITS-1:0] ACC_ROUND =
    {{(ACC_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] ACC_Y_MAX =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_Y_MIN =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [DIFF_BITS-1:0] DIFF_D_MAX =
    {{(DIFF_BITS-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
  localparam logic signed [DIFF_BITS-1:0] DIFF_D_MIN =
    {{(DIFF_BITS-DELAY_BITS+1){1'b1}}, {(DELAY_BITS-1){1'b0}}};

  // Request and result payloads.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          restart;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;
  } out_res_t;

  // One command per datapath step; at most one is active in a cycle.
  typedef struct packed {
    logic start;    // take a request, form b0*x
    logic do_acc;   // acc = d1 + b0*x, form b1*x
    logic do_y;     // round and saturate y, acc = d2 + b1*x, form b2*x
    logic do_b2;    // park b2*x in d2, form a1*y
    logic do_d1;    // d1 = acc - a1*y, form a2*y
    logic do_d2;    // d2 = b2*x - a2*y, load the result
  } iir_cmd_t;

  typedef struct packed {
    logic bypass;   // bypass register is set
    logic out_free; // output register can take a result this cycle
  } iir_sts_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          clip;
  } iir_round_t;

  // Round half up to sample width, then saturate.
  function automatic iir_round_t round_sat_sample(input logic signed [ACC_BITS-1:0] acc);
    logic signed [ACC_BITS-1:0] q;
    iir_round_t                 r;
    q = (acc + ACC_ROUND) >>> COEF_FRAC_BITS;
    if (q > ACC_Y_MAX) begin
      r.y    = ACC_Y_MAX[SAMPLE_BITS-1:0];
      r.clip = 1'b1;
    end else if (q < ACC_Y_MIN) begin
      r.y    = ACC_Y_MIN[SAMPLE_BITS-1:0];
      r.clip = 1'b1;
    end else begin
      r.y    = q[SAMPLE_BITS-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // Saturate a delay update to the delay register width.
  function automatic logic signed [DELAY_BITS-1:0] sat_delay(
    input logic signed [DIFF_BITS-1:0] v);
    logic signed [DELAY_BITS-1:0] r;
    if (v > DIFF_D_MAX) begin
      r = DIFF_D_MAX[DELAY_BITS-1:0];
    end else if (v < DIFF_D_MIN) begin
      r = DIFF_D_MIN[DELAY_BITS-1:0];
    end else begin
      r = v[DELAY_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/iir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_ctrl: sequencing state machine
// Walks one request through the five steps of the shared multiply-accumulate
// datapath and issues one command per cycle while busy, holding the last step until the output register is free.
// ----------------------------------------------------------------------------
module iir_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  iir_pkg::iir_sts_t sts,
  output iir_pkg::iir_cmd_t cmd,
  output logic              idle
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ACC  = 6'b000010,
    ST_Y    = 6'b000100,
    ST_B2   = 6'b001000,
    ST_D1   = 6'b010000,
    ST_D2   = 6'b100000
  } iir_state_t;

  iir_state_t state_r;
  iir_state_t state_nxt;
  logic       accept;

  // A bypassed request writes the output register at once, so it needs room.
  assign idle     = (state_r == ST_IDLE);
  assign in_stall = !idle || (sts.bypass && !sts.out_free);
  assign accept   = in_valid && !in_stall;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.start = accept;
        if (accept && !sts.bypass) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.do_acc = 1'b1;
        state_nxt  = ST_Y;
      end
      ST_Y: begin
        cmd.do_y  = 1'b1;
        state_nxt = ST_B2;
      end
      ST_B2: begin
        cmd.do_b2 = 1'b1;
        state_nxt = ST_D1;
      end
      ST_D1: begin
        cmd.do_d1 = 1'b1;
        state_nxt = ST_D2;
      end
      ST_D2: begin
        // Wait here until the previous result has been taken.
        cmd.do_d2 = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/iir_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_dp: biquad datapath
// Coefficient registers, one shared 18x16 multiplier with a product register,
// the accumulator, the two delay registers and the output register.
// ----------------------------------------------------------------------------
module iir_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  iir_pkg::in_req_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output iir_pkg::out_res_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [iir_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [iir_pkg::COEF_BITS-1:0]        cfg_wdata,
  input  iir_pkg::iir_cmd_t                    cmd,
  output iir_pkg::iir_sts_t                    sts
);

  // Configuration registers.
  logic signed [iir_pkg::COEF_BITS-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic                                 bypass_r;

  // Working registers.
  logic signed [iir_pkg::SAMPLE_BITS-1:0] x_r;
  logic signed [iir_pkg::PROD_BITS-1:0]   p_r;
  logic signed [iir_pkg::ACC_BITS-1:0]    acc_r;
  logic signed [iir_pkg::SAMPLE_BITS-1:0] y_r;
  logic                                   clip_r;
  logic signed [iir_pkg::DELAY_BITS-1:0]  d1_r;
  logic signed [iir_pkg::DELAY_BITS-1:0]  d2_r;
  logic                                   out_valid_r;
  iir_pkg::out_res_t                      out_data_r;

  logic signed [iir_pkg::COEF_BITS-1:0]   mul_a;
  logic signed [iir_pkg::SAMPLE_BITS-1:0] mul_b;
  logic signed [iir_pkg::PROD_BITS-1:0]   prod;
  iir_pkg::iir_round_t                    rnd;
  logic signed [iir_pkg::DIFF_BITS-1:0]   d1_diff;
  logic signed [iir_pkg::DIFF_BITS-1:0]   d2_diff;
  logic                                   load_out;

  assign sts.bypass   = bypass_r;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r     <= iir_pkg::COEF_ONE;
      b1_r     <= '0;
      b2_r     <= '0;
      a1_r     <= '0;
      a2_r     <= '0;
      bypass_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        iir_pkg::REG_B0:     b0_r     <= cfg_wdata;
        iir_pkg::REG_B1:     b1_r     <= cfg_wdata;
        iir_pkg::REG_B2:     b2_r     <= cfg_wdata;
        iir_pkg::REG_A1:     a1_r     <= cfg_wdata;
        iir_pkg::REG_A2:     a2_r     <= cfg_wdata;
        iir_pkg::REG_BYPASS: bypass_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = b0_r;
    mul_b = in_data.sample_in;
    if (cmd.do_acc) begin
      mul_a = b1_r;
      mul_b = x_r;
    end else if (cmd.do_y) begin
      mul_a = b2_r;
      mul_b = x_r;
    end else if (cmd.do_b2) begin
      mul_a = a1_r;
      mul_b = y_r;
    end else if (cmd.do_d1) begin
      mul_a = a2_r;
      mul_b = y_r;
    end
  end

  assign prod = mul_a * mul_b;
  assign rnd  = iir_pkg::round_sat_sample(acc_r);

  // Delay updates at full width before saturation.
  assign d1_diff = iir_pkg::DIFF_BITS'(acc_r) - iir_pkg::DIFF_BITS'(p_r);
  assign d2_diff = iir_pkg::DIFF_BITS'(d2_r) - iir_pkg::DIFF_BITS'(p_r);

  // Product, accumulator and sample registers.
  always_ff @(posedge clk) begin
    if (cmd.start || cmd.do_acc || cmd.do_y || cmd.do_b2 || cmd.do_d1) begin
      p_r <= prod;
    end
    if (cmd.start) begin
      x_r <= in_data.sample_in;
    end
    if (cmd.do_acc) begin
      acc_r <= iir_pkg::ACC_BITS'(d1_r) + iir_pkg::ACC_BITS'(p_r);
    end
    if (cmd.do_y) begin
      y_r    <= rnd.y;
      clip_r <= rnd.clip;
      if (iir_pkg::FILTER_ORDER >= 2) begin
        acc_r <= iir_pkg::ACC_BITS'(d2_r) + iir_pkg::ACC_BITS'(p_r);
      end else begin
        acc_r <= iir_pkg::ACC_BITS'(p_r);
      end
    end
  end

  // Delay registers; a restart request clears both.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else begin
      if (cmd.start && in_data.restart) begin
        d1_r <= '0;
        d2_r <= '0;
      end
      if (cmd.do_d1) begin
        d1_r <= iir_pkg::sat_delay(d1_diff);
      end
      if (iir_pkg::FILTER_ORDER >= 2) begin
        if (cmd.do_b2) begin
          d2_r <= iir_pkg::DELAY_BITS'(p_r);
        end
        if (cmd.do_d2) begin
          d2_r <= iir_pkg::sat_delay(d2_diff);
        end
      end
    end
  end

  // Output register: bypassed samples load on accept, filtered ones at the end.
  assign load_out = (cmd.start && bypass_r) || cmd.do_d2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && bypass_r) begin
      out_data_r.sample_out <= in_data.sample_in;
      out_data_r.clipped    <= 1'b0;
    end else if (cmd.do_d2) begin
      out_data_r.sample_out <= y_r;
      out_data_r.clipped    <= clip_r;
    end
  end

endmodule

>>> rtl/iir_df2t_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_df2t_filter_top: second-order IIR section, transposed direct form II
// One sample in, one rounded and saturated sample out, with two 40-bit delays
// updated through a single shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                             | Moves
//   --------+-----------------------------------+---------------------------
//   input   | in_valid, in_stall, in_data       | sample_in, restart
//   result  | out_valid, out_stall, out_data    | sample_out, clipped
//   config  | cfg_we, cfg_index, cfg_wdata      | coefficients, bypass
//
// A filtered request runs through the accept cycle and five steps of the
// shared 18x16 multiplier and accumulator, which forms the five products in turn.
// A bypassed request appears on the output in the cycle after it is accepted.
// Reset is synchronous; it restores the coefficients and clears both delays.
// The output register lets a new request start while a result waits; the
// last step holds while out_stall keeps the previous result in place.
// ----------------------------------------------------------------------------
module iir_df2t_filter_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  iir_pkg::in_req_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output iir_pkg::out_res_t                  out_data,
  input  logic                               cfg_we,
  input  logic [iir_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [iir_pkg::COEF_BITS-1:0]      cfg_wdata
);

  iir_pkg::iir_cmd_t cmd;
  iir_pkg::iir_sts_t sts;
  logic              idle;

  // Sequencer.
  iir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  // Arithmetic and storage.
  iir_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The sequencer never issues two datapath steps in one cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command active");

  // A filtered request keeps the input stalled on the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !sts.bypass) |=> (in_stall && !idle))
    else $error("input not stalled while a request is in work");

  // A bypassed request appears on the output next cycle, never marked clipped.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && sts.bypass) |=> (out_valid && !out_data.clipped))
    else $error("bypassed request did not reach the output");

  // The last step always leaves a result in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_d2 |=> (out_valid && idle))
    else $error("filtered result not loaded");

endmodule

>>> bench/iir_df2t_filter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_df2t_filter_top_tb: self-checking bench for the transposed biquad
// Drives filter requests with random gaps and output stalls, and reprograms
// the coefficients between phases. Every result is checked against a
// bit-accurate fixed-point model of the section kept inside the bench.
// ----------------------------------------------------------------------------
module iir_df2t_filter_top_tb;

  localparam int     HALF_PERIOD      = 5;
  localparam int     RESET_CYCLES     = 3;
  localparam int     QUIET_CYCLES     = 12;
  localparam int     LONG_HOLD_CYCLES = 300;
  localparam int     LIMIT_CYCLES     = 400000;
  localparam int     RANDOM_PHASES    = 10;
  localparam int     PHASE_ITEMS      = 195;
  localparam int     BUSY_PCT         = 76;
  localparam int     LIGHT_PCT        = 9;
  localparam longint ROUND_HALF       = longint'(1) <<< (iir_pkg::COEF_FRAC_BITS - 1);

  // Register indexes beyond the map; writes to them must be dropped.
  localparam logic [iir_pkg::CFG_INDEX_BITS-1:0] UNMAPPED_INDEX_LO = 3'd6;
  localparam logic [iir_pkg::CFG_INDEX_BITS-1:0] UNMAPPED_INDEX_HI = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Fixed-point model of the section and the queue of results it predicts.
  class biquad_checker;
    logic signed [iir_pkg::COEF_BITS-1:0] coef_b0 = iir_pkg::COEF_ONE;
    logic signed [iir_pkg::COEF_BITS-1:0] coef_b1 = '0;
    logic signed [iir_pkg::COEF_BITS-1:0] coef_b2 = '0;
    logic signed [iir_pkg::COEF_BITS-1:0] coef_a1 = '0;
    logic signed [iir_pkg::COEF_BITS-1:0] coef_a2 = '0;
    logic                                 bypass_on = 1'b0;
    longint                               near_delay = 0;
    longint                               far_delay = 0;
    iir_pkg::out_res_t                    awaited_outputs[$];
    int                                   errors = 0;

    function void write_register(logic [iir_pkg::CFG_INDEX_BITS-1:0] index,
                                 logic [iir_pkg::COEF_BITS-1:0] value);
      case (index)
        iir_pkg::REG_B0:     coef_b0 = value;
        iir_pkg::REG_B1:     coef_b1 = value;
        iir_pkg::REG_B2:     coef_b2 = value;
        iir_pkg::REG_A1:     coef_a1 = value;
        iir_pkg::REG_A2:     coef_a2 = value;
        iir_pkg::REG_BYPASS: bypass_on = value[0];
        default: ;
      endcase
    endfunction

    function longint clamp_signed(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // One step of the section: round half up, saturate, then update delays; bypass passes the sample through.
    function iir_pkg::out_res_t filter_sample(iir_pkg::in_req_t req);
      longint            x;
      longint            acc;
      longint            y_raw;
      longint            y;
      iir_pkg::out_res_t res;
      x = longint'($signed(req.sample_in));
      if (req.restart) begin
        near_delay = 0;
        far_delay  = 0;
      end
      if (bypass_on) begin
        res.sample_out = req.sample_in;
        res.clipped    = 1'b0;
        return res;
      end
      acc   = longint'(coef_b0) * x + near_delay;
      y_raw = (acc + ROUND_HALF) >>> iir_pkg::COEF_FRAC_BITS;
      y     = clamp_signed(y_raw, iir_pkg::SAMPLE_BITS);
      if (iir_pkg::FILTER_ORDER <= 1) begin
        near_delay = clamp_signed(longint'(coef_b1) * x - longint'(coef_a1) * y,
                                  iir_pkg::DELAY_BITS);
      end else begin
        near_delay = clamp_signed(far_delay + longint'(coef_b1) * x
                                  - longint'(coef_a1) * y, iir_pkg::DELAY_BITS);
        far_delay  = clamp_signed(longint'(coef_b2) * x - longint'(coef_a2) * y,
                                  iir_pkg::DELAY_BITS);
      end
      res.sample_out = y[iir_pkg::SAMPLE_BITS-1:0];
      res.clipped    = (y != y_raw);
      return res;
    endfunction

    function void note_sample(iir_pkg::in_req_t req);
      iir_pkg::out_res_t predicted;
      predicted       = filter_sample(req);
      awaited_outputs = {awaited_outputs, predicted};
    endfunction

    // Compare one result with the oldest prediction.
    function void check_output(iir_pkg::out_res_t got);
      iir_pkg::out_res_t want;
      if (awaited_outputs.size() == 0) begin
        $error("out_data: unexpected result, sample_out %0d clipped %0b",
               $signed(got.sample_out), got.clipped);
        errors++;
        return;
      end
      want = awaited_outputs.pop_front();
      if (got.sample_out !== want.sample_out) begin
        $error("sample_out: expected %0d, got %0d",
               $signed(want.sample_out), $signed(got.sample_out));
        errors++;
      end
      if (got.clipped !== want.clipped) begin
        $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited_outputs.size();
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  iir_pkg::in_req_t                   in_data = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  iir_pkg::out_res_t                  out_data;
  logic                               cfg_we = 1'b0;
  logic [iir_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [iir_pkg::COEF_BITS-1:0]      cfg_wdata = '0;

  biquad_checker tracker;
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;
  int            hold_requests = 0;
  int            holds_served = 0;
  int            hold_left = 0;
  int            cycle_count = 0;

  iir_df2t_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall    <= 1'b1;
      hold_left    <= LONG_HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Monitor: note each accepted request and check each accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_sample(in_data);
      if (out_valid && !out_stall) tracker.check_output(out_data);
    end
  end

  task automatic set_idle_mode(input idle_mode_t mode);
    sender_idle_pct    = (mode == IDLE_SENDER || mode == IDLE_RECEIVER) ? 0 : 0;
    receiver_stall_pct = 0;
    case (mode)
      IDLE_SENDER:   sender_idle_pct = BUSY_PCT;
      IDLE_RECEIVER: receiver_stall_pct = BUSY_PCT;
      IDLE_BOTH: begin
        sender_idle_pct    = LIGHT_PCT;
        receiver_stall_pct = LIGHT_PCT;
      end
      default: ;
    endcase
  endtask

  // Offer one request, with random idle cycles first, and wait for acceptance.
  task automatic offer_sample(input logic [iir_pkg::SAMPLE_BITS-1:0] value,
                              input logic restart_flag);
    iir_pkg::in_req_t req;
    req.sample_in = value;
    req.restart   = restart_flag;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [iir_pkg::CFG_INDEX_BITS-1:0] index,
                           input logic [iir_pkg::COEF_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.write_register(index, value);
  endtask

  task automatic program_filter(input int b0, input int b1, input int b2,
                                input int a1, input int a2, input bit bypass_set);
    write_reg(iir_pkg::REG_B0, iir_pkg::COEF_BITS'(b0));
    write_reg(iir_pkg::REG_B1, iir_pkg::COEF_BITS'(b1));
    write_reg(iir_pkg::REG_B2, iir_pkg::COEF_BITS'(b2));
    write_reg(iir_pkg::REG_A1, iir_pkg::COEF_BITS'(a1));
    write_reg(iir_pkg::REG_A2, iir_pkg::COEF_BITS'(a2));
    write_reg(iir_pkg::REG_BYPASS, iir_pkg::COEF_BITS'(bypass_set));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [iir_pkg::SAMPLE_BITS-1:0] pick_sample(input int style);
    logic [iir_pkg::SAMPLE_BITS-1:0] v;
    case (style)
      0: v = iir_pkg::SAMPLE_BITS'($urandom);
      1: v = iir_pkg::SAMPLE_BITS'(int'($urandom_range(0, 4095)) - 2048);
      2: begin
        case ($urandom_range(4))
          0: v = 16'sd32767;
          1: v = -16'sd32768;
          2: v = 16'sd0;
          3: v = 16'sd1;
          default: v = -16'sd1;
        endcase
      end
      default: begin
        v = iir_pkg::SAMPLE_BITS'($urandom_range(16384, 32767));
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Signals are runs that mostly begin with a restart; a few continue the
  // previous state or carry a stray restart in the middle.
  task automatic stream_signal(input int item_count);
    int   sent;
    int   seg_left;
    int   style;
    logic restart_flag;
    sent     = 0;
    seg_left = 0;
    style    = 0;
    while (sent < item_count) begin
      if (seg_left == 0) begin
        seg_left     = $urandom_range(1, 48);
        style        = $urandom_range(0, 3);
        restart_flag = ($urandom_range(9) != 0);
      end else begin
        restart_flag = ($urandom_range(99) < 3);
      end
      offer_sample(pick_sample(style), restart_flag);
      seg_left--;
      sent++;
    end
  endtask

  initial begin
    tracker = new;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients give unity gain, so samples come back unchanged.
    set_idle_mode(IDLE_NONE);
    offer_sample(16'sd32767, 1'b1);
    offer_sample(-16'sd32768, 1'b0);
    offer_sample(16'sd0, 1'b0);
    offer_sample(16'sd1, 1'b0);
    offer_sample(-16'sd1, 1'b0);
    settle();

    // Largest gain saturates the output in both directions.
    program_filter(131071, 0, 0, 0, 0, 0);
    offer_sample(16'sd32767, 1'b1);
    offer_sample(-16'sd32768, 1'b0);
    settle();
    program_filter(-131072, 0, 0, 0, 0, 0);
    offer_sample(-16'sd32768, 1'b1);
    settle();

    // Every coefficient at a corner drives the delays as hard as they go.
    program_filter(131071, -131072, 131071, -131072, 131071, 0);
    offer_sample(16'sd32767, 1'b1);
    offer_sample(-16'sd32768, 1'b0);
    offer_sample(16'sd32767, 1'b0);
    settle();

    // Bypass passes samples through; a restart still clears the delays.
    program_filter(131071, -131072, 131071, -131072, 131071, 1);
    offer_sample(16'sd12345, 1'b0);
    offer_sample(-16'sd32768, 1'b1);
    offer_sample(16'sd32767, 1'b0);
    settle();
    program_filter(131071, -131072, 131071, -131072, 131071, 0);
    offer_sample(-16'sd1, 1'b0);
    settle();

    // Writes outside the register map must leave the filter untouched.
    write_reg(UNMAPPED_INDEX_LO, 18'h3ffff);
    write_reg(UNMAPPED_INDEX_HI, 18'h00001);
    cfg_we <= 1'b0;
    offer_sample(16'sd100, 1'b0);
    settle();

    // Random phases across coefficient sets and idle patterns.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_idle_mode(idle_mode_t'(phase % 4));
      case (phase % 5)
        0: program_filter(4424, 8848, 4424, -91750, 37356, 0);
        1: program_filter(int'($urandom_range(0, 80000)) - 40000,
                          int'($urandom_range(0, 80000)) - 40000,
                          int'($urandom_range(0, 80000)) - 40000,
                          int'($urandom_range(0, 200000)) - 100000,
                          int'($urandom_range(0, 70000)) - 20000, 0);
        2: program_filter($urandom, $urandom, $urandom, $urandom, $urandom, 0);
        3: begin
          if (phase < 5) begin
            program_filter(131071, 131071, 131071, -131072, -131072, 0);
          end else begin
            program_filter(int'(iir_pkg::COEF_ONE), 0, 0, 0, 0, 0);
          end
        end
        default: program_filter($urandom, $urandom, $urandom, $urandom, $urandom, 1);
      endcase
      // Hold the output off for a long stretch while requests keep coming.
      if (phase == 0) hold_requests = hold_requests + 1;
      stream_signal(PHASE_ITEMS);
      settle();
    end

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> iir_df2t_filter_top.f
rtl/iir_pkg.sv
rtl/iir_ctrl.sv
rtl/iir_dp.sv
rtl/iir_df2t_filter_top.sv
bench/iir_df2t_filter_top_tb.sv
